FILE: rtl/mgpc_pkg.sv
// Shared types and constants for the multi-gain pixel calibrator.
// No dependencies; every other file of the block imports this package.
package mgpc_pkg;

    localparam int RAW_W     = 16;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 40;
    localparam int RANGE_W   = 2;
    localparam int FINE_W    = 8;
    localparam int COARSE_W  = 5;
    localparam int RANGE_LSB = 13;
    localparam int FINE_LSB  = 5;
    localparam int COARSE_LSB = 0;
    localparam int ADC_BASE  = 4096;
    localparam int SPLIT_W   = 24;
    localparam int SUB_W     = COEF_W + 1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OUT_W-1:0]  value_t;
    typedef logic signed [SUB_W-1:0]  sub_t;

    typedef enum logic [RANGE_W-1:0] {
        RANGE_0 = 2'd0,
        RANGE_1 = 2'd1,
        RANGE_2 = 2'd2,
        RANGE_3 = 2'd3
    } gain_range_t;

    localparam coef_t  R3_SCALE_RESET = 32'sd65536;
    localparam value_t OUT_MAX = 40'sh7F_FFFF_FFFF;
    localparam value_t OUT_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        value_t      adc;
        sub_t        sub;
        coef_t       scale;
        gain_range_t rng;
    } mgpc_adc_t;

endpackage

FILE: rtl/mgpc_in_if.sv
// Input channel: one raw pixel word and its calibration words per request.
// Depends on mgpc_pkg.
interface mgpc_in_if import mgpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pixel;
    coef_t            coarse_gain;
    coef_t            coarse_offset;
    coef_t            fine_gain;
    coef_t            fine_offset;
    coef_t            reset_level;
    coef_t            pedestal_r0;
    coef_t            pedestal_r1;
    coef_t            pedestal_r2;
    coef_t            scale_r0;
    coef_t            scale_r1;
    coef_t            scale_r2;

    modport source (
        output valid, raw_pixel, coarse_gain, coarse_offset, fine_gain, fine_offset,
               reset_level, pedestal_r0, pedestal_r1, pedestal_r2,
               scale_r0, scale_r1, scale_r2,
        input  ready
    );

    modport sink (
        input  valid, raw_pixel, coarse_gain, coarse_offset, fine_gain, fine_offset,
               reset_level, pedestal_r0, pedestal_r1, pedestal_r2,
               scale_r0, scale_r1, scale_r2,
        output ready
    );
endinterface

FILE: rtl/mgpc_out_if.sv
// Output channel: one calibrated pixel and its gain range per request.
// Depends on mgpc_pkg.
interface mgpc_out_if import mgpc_pkg::*; ();
    logic        valid;
    logic        ready;
    value_t      calibrated_value;
    gain_range_t gain_range;

    modport source (
        output valid, calibrated_value, gain_range,
        input  ready
    );

    modport sink (
        input  valid, calibrated_value, gain_range,
        output ready
    );
endinterface

FILE: rtl/mgpc_adc.sv
// Front three pipeline stages: field decode and offset removal, ADC gain
// products, and the saturated ADC sum. Depends on mgpc_pkg and mgpc_in_if.
module mgpc_adc import mgpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mgpc_in_if.sink    pix_in,
    input  coef_t      range3_scale,
    output logic       dn_valid,
    input  logic       dn_ready,
    output mgpc_adc_t  dn_data
);

    localparam int SPAN_W = (FINE_W + FRAC_BITS > COEF_W - 1) ? FINE_W + FRAC_BITS : COEF_W - 1;
    localparam int DIFF_W = SPAN_W + 2;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 2;
    localparam logic signed [SUM_W-1:0] ADC_BASE_FX = SUM_W'(ADC_BASE) << FRAC_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic go1, go2, go3;

    gain_range_t             rng_w;
    logic [FINE_W-1:0]       fine_w;
    logic [COARSE_W-1:0]     coarse_w;
    logic signed [DIFF_W-1:0] dc_next, df_next;
    sub_t                    sub_next;
    coef_t                   scale_next;

    logic signed [DIFF_W-1:0] dc_reg, df_reg;
    coef_t                    cg_reg, fg_reg;
    sub_t                     sub1_reg, sub2_reg, sub3_reg;
    coef_t                    scale1_reg, scale2_reg, scale3_reg;
    gain_range_t              rng1_reg, rng2_reg, rng3_reg;

    logic signed [PROD_W-1:0] pc_next, pf_next, pc_reg, pf_reg;
    logic signed [SUM_W-1:0]  sum_w;
    value_t                   adc_next, adc3_reg;

    assign go3 = !v3_reg || dn_ready;
    assign go2 = !v2_reg || go3;
    assign go1 = !v1_reg || go2;
    assign pix_in.ready = go1;

    always_comb
    begin
        rng_w    = gain_range_t'(pix_in.raw_pixel[RANGE_LSB +: RANGE_W]);
        fine_w   = pix_in.raw_pixel[FINE_LSB +: FINE_W];
        coarse_w = pix_in.raw_pixel[COARSE_LSB +: COARSE_W];
        dc_next  = $signed({{(DIFF_W-COARSE_W-FRAC_BITS){1'b0}}, coarse_w, {FRAC_BITS{1'b0}}})
                   - DIFF_W'(pix_in.coarse_offset);
        df_next  = $signed({{(DIFF_W-FINE_W-FRAC_BITS){1'b0}}, fine_w, {FRAC_BITS{1'b0}}})
                   - DIFF_W'(pix_in.fine_offset);
        case (rng_w)
            RANGE_0:
            begin
                sub_next   = SUB_W'(pix_in.reset_level) + SUB_W'(pix_in.pedestal_r0);
                scale_next = pix_in.scale_r0;
            end
            RANGE_1:
            begin
                sub_next   = SUB_W'(pix_in.pedestal_r1);
                scale_next = pix_in.scale_r1;
            end
            RANGE_2:
            begin
                sub_next   = SUB_W'(pix_in.pedestal_r2);
                scale_next = pix_in.scale_r2;
            end
            default:
            begin
                sub_next   = '0;
                scale_next = range3_scale;
            end
        endcase
    end

    assign pc_next = PROD_W'(dc_reg) * PROD_W'(cg_reg);
    assign pf_next = PROD_W'(df_reg) * PROD_W'(fg_reg);

    always_comb
    begin
        sum_w = ADC_BASE_FX + SUM_W'(pc_reg >>> FRAC_BITS) + SUM_W'(pf_reg >>> FRAC_BITS);
        if (sum_w[SUM_W-1:OUT_W-1] != {(SUM_W-OUT_W+1){sum_w[SUM_W-1]}})
        begin
            adc_next = sum_w[SUM_W-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            adc_next = sum_w[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (go1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (go2)
            begin
                v2_reg <= v1_reg;
            end
            if (go3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            dc_reg     <= dc_next;
            df_reg     <= df_next;
            cg_reg     <= pix_in.coarse_gain;
            fg_reg     <= pix_in.fine_gain;
            sub1_reg   <= sub_next;
            scale1_reg <= scale_next;
            rng1_reg   <= rng_w;
        end
        if (go2)
        begin
            pc_reg     <= pc_next;
            pf_reg     <= pf_next;
            sub2_reg   <= sub1_reg;
            scale2_reg <= scale1_reg;
            rng2_reg   <= rng1_reg;
        end
        if (go3)
        begin
            adc3_reg   <= adc_next;
            sub3_reg   <= sub2_reg;
            scale3_reg <= scale2_reg;
            rng3_reg   <= rng2_reg;
        end
    end

    assign dn_valid      = v3_reg;
    assign dn_data.adc   = adc3_reg;
    assign dn_data.sub   = sub3_reg;
    assign dn_data.scale = scale3_reg;
    assign dn_data.rng   = rng3_reg;

`ifndef NO_ASSERTIONS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("Input blocked while a front stage is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> v1_reg)
        else $error("Accepted request did not enter the first stage");

    a_range_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && go3) |=> (v3_reg && rng3_reg == $past(rng2_reg)))
        else $error("Gain range lost between the product and sum stages");
`endif

endmodule

FILE: rtl/mgpc_scale.sv
// Back three pipeline stages: pedestal removal, split scale products and the
// saturated output register. Depends on mgpc_pkg and mgpc_out_if.
module mgpc_scale import mgpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  mgpc_adc_t  up_data,
    mgpc_out_if.source cal_out
);

    localparam int DV_W   = OUT_W + 2;
    localparam int PLO_W  = SPLIT_W + 1 + COEF_W;
    localparam int PHI_W  = OUT_W - SPLIT_W + COEF_W;
    localparam int FULL_W = OUT_W + COEF_W;

    logic v4_reg, v5_reg, v6_reg;
    logic go4, go5, go6;

    logic signed [DV_W-1:0]   dv_w;
    value_t                   v_next, val4_reg;
    coef_t                    scale4_reg;
    gain_range_t              rng4_reg, rng5_reg, rng6_reg;

    logic signed [PLO_W-1:0]  plo_next, plo_reg;
    logic signed [PHI_W-1:0]  phi_next, phi_reg;
    logic signed [FULL_W-1:0] full_w, shr_w;
    value_t                   out_next, out_reg;

    assign go6 = !v6_reg || cal_out.ready;
    assign go5 = !v5_reg || go6;
    assign go4 = !v4_reg || go5;
    assign up_ready = go4;

    always_comb
    begin
        dv_w = DV_W'(up_data.adc) - DV_W'(up_data.sub);
        if (dv_w[DV_W-1:OUT_W-1] != {(DV_W-OUT_W+1){dv_w[DV_W-1]}})
        begin
            v_next = dv_w[DV_W-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            v_next = dv_w[OUT_W-1:0];
        end
    end

    assign plo_next = PLO_W'($signed({1'b0, val4_reg[SPLIT_W-1:0]})) * PLO_W'(scale4_reg);
    assign phi_next = PHI_W'($signed(val4_reg[OUT_W-1:SPLIT_W])) * PHI_W'(scale4_reg);

    always_comb
    begin
        full_w = (FULL_W'(phi_reg) <<< SPLIT_W) + FULL_W'(plo_reg);
        shr_w  = full_w >>> FRAC_BITS;
        if (shr_w[FULL_W-1:OUT_W-1] != {(FULL_W-OUT_W+1){shr_w[FULL_W-1]}})
        begin
            out_next = shr_w[FULL_W-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            out_next = shr_w[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (go4)
            begin
                v4_reg <= up_valid;
            end
            if (go5)
            begin
                v5_reg <= v4_reg;
            end
            if (go6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go4)
        begin
            val4_reg   <= v_next;
            scale4_reg <= up_data.scale;
            rng4_reg   <= up_data.rng;
        end
        if (go5)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            rng5_reg <= rng4_reg;
        end
        if (go6)
        begin
            out_reg  <= out_next;
            rng6_reg <= rng5_reg;
        end
    end

    assign cal_out.valid            = v6_reg;
    assign cal_out.calibrated_value = out_reg;
    assign cal_out.gain_range       = rng6_reg;

`ifndef NO_ASSERTIONS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !up_ready |-> (v4_reg && v5_reg && v6_reg))
        else $error("Back stages blocked while one of them is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> v4_reg)
        else $error("Request from the front stages was dropped");

    a_range3_no_pedestal: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && up_data.rng == RANGE_3) |=> (val4_reg == $past(up_data.adc)))
        else $error("Range 3 pixel altered by pedestal removal");
`endif

endmodule

FILE: rtl/multi_gain_pixel_calibrator.sv
// Top level of the multi-gain pixel calibrator: range 3 scale register and
// the two pipeline halves. Depends on mgpc_pkg, mgpc_in_if, mgpc_out_if,
// mgpc_adc and mgpc_scale.
//
// Usage:
// Each request on pix_in carries one raw pixel word and all of that pixel's
// calibration words; each request on cal_out returns the calibrated value in
// signed fixed point with FRAC_BITS fraction bits, saturated to 40 bits, and
// the decoded gain range. Requests leave in the order they arrive.
// The pipeline has six register stages, and a new pixel may be accepted every
// cycle while cal_out.ready is held high.
// The latency is set by the two multiply stages, the ADC sum and the split
// 40 by 32 bit scale product that is completed over two stages.
// When the receiver holds cal_out.ready low, the result waits in the output
// register, empty stages ahead of it still fill, and pix_in.ready falls only
// once all six stages are occupied. Nothing is lost or repeated.
// The range 3 scale is written through cfg_wr_en and cfg_wr_data and should
// only change while the pipeline is empty. Reset empties the pipeline and
// sets the range 3 scale to 65536.
module multi_gain_pixel_calibrator import mgpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  coef_t      cfg_wr_data,
    mgpc_in_if.sink    pix_in,
    mgpc_out_if.source cal_out
);

    coef_t     range3_scale_reg;
    logic      mid_valid;
    logic      mid_ready;
    mgpc_adc_t mid_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range3_scale_reg <= R3_SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            range3_scale_reg <= cfg_wr_data;
        end
    end

    mgpc_adc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_adc (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_in),
        .range3_scale (range3_scale_reg),
        .dn_valid     (mid_valid),
        .dn_ready     (mid_ready),
        .dn_data      (mid_data)
    );

    mgpc_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_data  (mid_data),
        .cal_out  (cal_out)
    );

endmodule

FILE: tb/tb_multi_gain_pixel_calibrator.sv
// Self-checking testbench for multi_gain_pixel_calibrator: directed and random pixel
// requests with random idling on both channels, checked against a fixed-point predictor.
// Depends on mgpc_pkg, mgpc_in_if, mgpc_out_if and the calibrator RTL.
module tb_multi_gain_pixel_calibrator;
    import mgpc_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 280;

    typedef logic signed [95:0] wide_t;

    localparam wide_t SAT_HI = 96'sd549755813887;
    localparam wide_t SAT_LO = -96'sd549755813888;

    typedef struct {
        logic [RAW_W-1:0] raw_pixel;
        coef_t            coarse_gain;
        coef_t            coarse_offset;
        coef_t            fine_gain;
        coef_t            fine_offset;
        coef_t            reset_level;
        coef_t            pedestal_r0;
        coef_t            pedestal_r1;
        coef_t            pedestal_r2;
        coef_t            scale_r0;
        coef_t            scale_r1;
        coef_t            scale_r2;
    } pixel_req_t;

    typedef struct {
        value_t      value;
        gain_range_t rng;
    } cal_result_t;

    class pixel_scoreboard;
        cal_result_t pending[$];
        coef_t       scale_r3;
        int          errors;
        int          checked;

        function new();
            scale_r3 = R3_SCALE_RESET;
            errors   = 0;
            checked  = 0;
        endfunction

        function wide_t mul_q(wide_t a, wide_t b);
            wide_t p;
            p = a * b;
            return p >>> FRAC_BITS;
        endfunction

        function wide_t clamp40(wide_t x);
            if (x > SAT_HI)
                return SAT_HI;
            if (x < SAT_LO)
                return SAT_LO;
            return x;
        endfunction

        function cal_result_t calibrate(pixel_req_t r);
            cal_result_t res;
            int          fine;
            int          coarse;
            wide_t       dc;
            wide_t       df;
            wide_t       adc;
            wide_t       v;
            coef_t       scale;
            fine    = r.raw_pixel[12:5];
            coarse  = r.raw_pixel[4:0];
            res.rng = gain_range_t'(r.raw_pixel[14:13]);
            dc  = (wide_t'(coarse) <<< FRAC_BITS) - wide_t'(r.coarse_offset);
            df  = (wide_t'(fine) <<< FRAC_BITS) - wide_t'(r.fine_offset);
            adc = clamp40((wide_t'(ADC_BASE) <<< FRAC_BITS)
                          + mul_q(dc, wide_t'(r.coarse_gain))
                          + mul_q(df, wide_t'(r.fine_gain)));
            case (res.rng)
                RANGE_0:
                begin
                    v     = clamp40(adc - wide_t'(r.reset_level) - wide_t'(r.pedestal_r0));
                    scale = r.scale_r0;
                end
                RANGE_1:
                begin
                    v     = clamp40(adc - wide_t'(r.pedestal_r1));
                    scale = r.scale_r1;
                end
                RANGE_2:
                begin
                    v     = clamp40(adc - wide_t'(r.pedestal_r2));
                    scale = r.scale_r2;
                end
                default:
                begin
                    v     = adc;
                    scale = scale_r3;
                end
            endcase
            res.value = value_t'(clamp40(mul_q(v, wide_t'(scale))));
            return res;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void note_request(pixel_req_t r);
            pending.push_back(calibrate(r));
        endfunction

        task check_result(value_t value, gain_range_t rng);
            cal_result_t want;
            if (pending.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (value !== want.value)
                report($sformatf("calibrated_value %0d, expected %0d", value, want.value));
            if (rng !== want.rng)
                report($sformatf("gain_range %0d, expected %0d", rng, want.rng));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    coef_t cfg_wr_data;

    mgpc_in_if  pix_in ();
    mgpc_out_if cal_out ();

    multi_gain_pixel_calibrator #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix_in      (pix_in),
        .cal_out     (cal_out)
    );

    pixel_scoreboard sb = new();

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_req  = 1'b0;
    int sent      = 0;
    int settings  = 1;
    int cycles    = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_multi_gain_pixel_calibrator: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cal_out.valid && cal_out.ready)
            sb.check_result(cal_out.calibrated_value, cal_out.gain_range);
    end

    initial
    begin
        int gap;
        cal_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                cal_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                cal_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cal_out.ready <= 1'b1;
            @(posedge clk);
            while (!cal_out.valid)
                @(posedge clk);
        end
    end

    function automatic logic [RAW_W-1:0] pack_raw(bit top, int rng, int fine, int coarse);
        return {top, 2'(rng), 8'(fine), 5'(coarse)};
    endfunction

    function automatic pixel_req_t typical_req(logic [RAW_W-1:0] raw);
        pixel_req_t r;
        r.raw_pixel     = raw;
        r.coarse_gain   = 32'sd131072;
        r.coarse_offset = 32'sd65536;
        r.fine_gain     = 32'sd65536;
        r.fine_offset   = 32'sd0;
        r.reset_level   = 32'sd6553600;
        r.pedestal_r0   = 32'sd655360;
        r.pedestal_r1   = 32'sd1310720;
        r.pedestal_r2   = 32'sd1966080;
        r.scale_r0      = 32'sd65536;
        r.scale_r1      = 32'sd32768;
        r.scale_r2      = -32'sd98304;
        return r;
    endfunction

    function automatic pixel_req_t fill_req(logic [RAW_W-1:0] raw, coef_t c);
        pixel_req_t r;
        r.raw_pixel     = raw;
        r.coarse_gain   = c;
        r.coarse_offset = c;
        r.fine_gain     = c;
        r.fine_offset   = c;
        r.reset_level   = c;
        r.pedestal_r0   = c;
        r.pedestal_r1   = c;
        r.pedestal_r2   = c;
        r.scale_r0      = c;
        r.scale_r1      = c;
        r.scale_r2      = c;
        return r;
    endfunction

    function automatic coef_t rand_coef(bit wild);
        case ($urandom_range(0, 15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            default:
            begin
                if (wild)
                    return coef_t'($urandom);
                return coef_t'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            end
        endcase
    endfunction

    function automatic pixel_req_t rand_req();
        pixel_req_t r;
        bit         wild;
        wild            = ($urandom_range(0, 3) == 0);
        r.raw_pixel     = RAW_W'($urandom_range(0, 16'hFFFF));
        r.coarse_gain   = rand_coef(wild);
        r.coarse_offset = rand_coef(wild);
        r.fine_gain     = rand_coef(wild);
        r.fine_offset   = rand_coef(wild);
        r.reset_level   = rand_coef(wild);
        r.pedestal_r0   = rand_coef(wild);
        r.pedestal_r1   = rand_coef(wild);
        r.pedestal_r2   = rand_coef(wild);
        r.scale_r0      = rand_coef(wild);
        r.scale_r1      = rand_coef(wild);
        r.scale_r2      = rand_coef(wild);
        return r;
    endfunction

    task automatic send_pixel(input pixel_req_t r);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid         <= 1'b1;
        pix_in.raw_pixel     <= r.raw_pixel;
        pix_in.coarse_gain   <= r.coarse_gain;
        pix_in.coarse_offset <= r.coarse_offset;
        pix_in.fine_gain     <= r.fine_gain;
        pix_in.fine_offset   <= r.fine_offset;
        pix_in.reset_level   <= r.reset_level;
        pix_in.pedestal_r0   <= r.pedestal_r0;
        pix_in.pedestal_r1   <= r.pedestal_r1;
        pix_in.pedestal_r2   <= r.pedestal_r2;
        pix_in.scale_r0      <= r.scale_r0;
        pix_in.scale_r1      <= r.scale_r1;
        pix_in.scale_r2      <= r.scale_r2;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_range3_scale(input coef_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.scale_r3 = v;
        settings++;
    endtask

    initial
    begin
        pixel_req_t r;
        coef_t      r3_values[6];
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        pix_in.valid         <= 1'b0;
        pix_in.raw_pixel     <= '0;
        pix_in.coarse_gain   <= '0;
        pix_in.coarse_offset <= '0;
        pix_in.fine_gain     <= '0;
        pix_in.fine_offset   <= '0;
        pix_in.reset_level   <= '0;
        pix_in.pedestal_r0   <= '0;
        pix_in.pedestal_r1   <= '0;
        pix_in.pedestal_r2   <= '0;
        pix_in.scale_r0      <= '0;
        pix_in.scale_r1      <= '0;
        pix_in.scale_r2      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typical calibration words across every range and the field extremes.
        for (int g = 0; g < 4; g++)
        begin
            send_pixel(typical_req(pack_raw(1'b0, g, 0, 0)));
            send_pixel(typical_req(pack_raw(1'b0, g, 255, 31)));
        end
        send_pixel(typical_req(16'hFFFF));
        send_pixel(typical_req(16'h7FFF));
        send_pixel(typical_req(16'h8000));
        send_pixel(fill_req(16'h0000, 32'sd0));
        // Saturation of the ADC sum, the pedestal subtraction and the final product.
        for (int g = 0; g < 4; g++)
        begin
            send_pixel(fill_req(pack_raw(1'b0, g, 0, 0), 32'sh7FFF_FFFF));
            send_pixel(fill_req(pack_raw(1'b1, g, 255, 31), 32'sh8000_0000));
        end
        r = fill_req(pack_raw(1'b0, 0, 255, 31), 32'sh8000_0000);
        r.coarse_gain = 32'sh7FFF_FFFF;
        r.fine_gain   = 32'sh7FFF_FFFF;
        send_pixel(r);
        // Range 1 with the unused words set to noise.
        r = rand_req();
        r.raw_pixel   = pack_raw(1'b0, 1, 77, 9);
        r.pedestal_r1 = 32'sd12345;
        r.scale_r1    = -32'sd1;
        send_pixel(r);
        // Fractional negative product, to exercise rounding towards minus infinity.
        r = typical_req(pack_raw(1'b0, 2, 3, 1));
        r.fine_gain = 32'sd1;
        r.scale_r2  = -32'sd3;
        send_pixel(r);
        wait_drained();

        r3_values[0] = 32'sh7FFF_FFFF;
        r3_values[1] = 32'sh8000_0000;
        r3_values[2] = 32'sd0;
        r3_values[3] = -32'sd65536;
        r3_values[4] = coef_t'($urandom);
        r3_values[5] = 32'sd196608;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_range3_scale(r3_values[ph]);
            send_idle = (ph != 2 && ph != 1);
            recv_idle = (ph != 2);
            if (ph == 1)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pixel(rand_req());
            wait_drained();
        end

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("Run covered %0d pixel requests in all four gain ranges under %0d range 3 scales.",
                 sent, settings);
        $display("%0d results checked, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("tb_multi_gain_pixel_calibrator: PASS");
        else
            $display("tb_multi_gain_pixel_calibrator: FAIL");
        $finish;
    end

endmodule
